[sv/ulhc_pkg.sv]
// Shared constants and types for the UTF-8 last-Hangul classifier.
`default_nettype none
package ulhc_pkg;

   // Hangul syllable block
   localparam logic [15:0] HANGUL_FIRST = 16'hAC00;
   localparam logic [15:0] HANGUL_LAST  = 16'hD7A3;
   localparam int          FINAL_COUNT  = 28;
   localparam int          VOWEL_COUNT  = 21;

   // UTF-8 byte class masks and patterns
   localparam logic [7:0] ASCII_LIMIT  = 8'h80;
   localparam logic [7:0] CONT_MASK    = 8'hC0;
   localparam logic [7:0] CONT_PATTERN = 8'h80;
   localparam logic [7:0] LEAD2_MASK   = 8'hE0;
   localparam logic [7:0] LEAD2_PAT    = 8'hC0;
   localparam logic [7:0] LEAD3_MASK   = 8'hF0;
   localparam logic [7:0] LEAD3_PAT    = 8'hE0;
   localparam logic [7:0] LEAD4_MASK   = 8'hF8;
   localparam logic [7:0] LEAD4_PAT    = 8'hF0;
   localparam logic [5:0] PAYLOAD_MASK = 6'h3F;

   // Reciprocal multipliers: (x * RECIP) >> RECIP_SHIFT is exact over the ranges used
   localparam logic [11:0] RECIP7      = 12'd2341;   // x < 2793
   localparam logic [9:0]  RECIP21     = 10'd781;    // x < 399
   localparam int          RECIP_SHIFT = 14;

   localparam int OFFSET_W = 14;
   localparam int RSP_W    = 32;

   // End-of-string summary taken from the decoder state
   typedef struct packed {
      logic                decoded_ok;
      logic                syllable_seen;
      logic [OFFSET_W-1:0] offset;
   } ulhc_sum_type;

endpackage
`default_nettype wire

[sv/ulhc_decoder.sv]
// UTF-8 byte decoder that tracks the last Hangul syllable of a string.
`default_nettype none
module ulhc_decoder
   import ulhc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         accept,
   input  wire logic [7:0]   in_byte,
   output ulhc_sum_type      summary
);

   logic [17:0]         partial_ff, partial_in;
   logic [1:0]          pending_ff, pending_in;
   logic                failed_ff, failed_in;
   logic                have_ff, have_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;

   logic [23:0] cont_cp;
   logic [15:0] cp_offset;
   logic        cp_hangul;

   assign cont_cp   = {partial_ff, in_byte[5:0] & PAYLOAD_MASK};
   assign cp_hangul = (cont_cp >= {8'd0, HANGUL_FIRST}) && (cont_cp <= {8'd0, HANGUL_LAST});
   assign cp_offset = cont_cp[15:0] - HANGUL_FIRST;

   always_comb begin
      partial_in = partial_ff;
      pending_in = pending_ff;
      failed_in  = failed_ff;
      have_in    = have_ff;
      offset_in  = offset_ff;
      if (in_byte == 8'd0) begin
         partial_in = '0;
         pending_in = '0;
         failed_in  = 1'b0;
         have_in    = 1'b0;
         offset_in  = '0;
      end else if (failed_ff) begin
         // skip to end of string
      end else if (pending_ff != 2'd0) begin
         if ((in_byte & CONT_MASK) != CONT_PATTERN) begin
            failed_in  = 1'b1;
            pending_in = '0;
            partial_in = '0;
         end else begin
            pending_in = pending_ff - 2'd1;
            if (pending_ff == 2'd1) begin
               partial_in = '0;
               if (cp_hangul) begin
                  have_in   = 1'b1;
                  offset_in = cp_offset[OFFSET_W-1:0];
               end
            end else begin
               partial_in = cont_cp[17:0];
            end
         end
      end else if (in_byte < ASCII_LIMIT) begin
         // plain ASCII, never a syllable
      end else if ((in_byte & LEAD2_MASK) == LEAD2_PAT) begin
         partial_in = {13'd0, in_byte[4:0]};
         pending_in = 2'd1;
      end else if ((in_byte & LEAD3_MASK) == LEAD3_PAT) begin
         partial_in = {14'd0, in_byte[3:0]};
         pending_in = 2'd2;
      end else if ((in_byte & LEAD4_MASK) == LEAD4_PAT) begin
         partial_in = {15'd0, in_byte[2:0]};
         pending_in = 2'd3;
      end else begin
         failed_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         pending_ff <= '0;
         failed_ff  <= 1'b0;
         have_ff    <= 1'b0;
         offset_ff  <= '0;
      end else if (accept) begin
         partial_ff <= partial_in;
         pending_ff <= pending_in;
         failed_ff  <= failed_in;
         have_ff    <= have_in;
         offset_ff  <= offset_in;
      end
   end

   always_comb begin
      summary.decoded_ok    = !failed_ff && (pending_ff == 2'd0);
      summary.syllable_seen = summary.decoded_ok && have_ff;
      summary.offset        = summary.syllable_seen ? offset_ff : '0;
   end

   // a failed string never has a sequence in flight
   a_fail_no_pending: assert property (@(posedge clock) disable iff (reset)
      failed_ff |-> (pending_ff == 2'd0 && partial_ff == '0))
      else $error("pending sequence after failure");

   // a zero byte always leaves a clean state
   a_zero_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && in_byte == 8'd0) |=> (!failed_ff && !have_ff && pending_ff == 2'd0))
      else $error("state not cleared at end of string");

   // no partial code is held while no sequence is open
   a_partial_idle: assert property (@(posedge clock) disable iff (reset)
      (pending_ff == 2'd0) |-> (partial_ff == '0))
      else $error("stale partial code");

endmodule
`default_nettype wire

[sv/ulhc_split.sv]
// Result pipeline: splits the syllable offset into vowel and final indices.
`default_nettype none
module ulhc_split
   import ulhc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire ulhc_sum_type     in_sum,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata
);

   logic va_ff, vb_ff, vc_ff, vd_ff;
   logic va_in, vb_in, vc_in, vd_in;
   logic ready_b, ready_c, ready_d;

   // stage A: summary
   ulhc_sum_type        a_ff;
   // stage B: offset / 28
   ulhc_sum_type        b_ff;
   logic [8:0]          b_q_ff, b_q_in;
   logic [23:0]         b_prod;
   // stage C: quotient / 21, final index
   ulhc_sum_type        c_ff;
   logic [8:0]          c_q_ff;
   logic [4:0]          c_qq_ff, c_qq_in;
   logic [4:0]          c_fin_ff, c_fin_in;
   logic [18:0]         c_prod;
   logic [OFFSET_W-1:0] c_fin_full;
   // stage D: output register
   logic [RSP_W-1:0]    d_ff, d_in;
   logic [8:0]          d_vowel_full;
   logic [4:0]          d_vowel;
   logic [15:0]         d_last;
   logic                d_pos, d_fvl;

   assign ready_d  = !vd_ff || rsp_tready;
   assign ready_c  = !vc_ff || ready_d;
   assign ready_b  = !vb_ff || ready_c;
   assign in_ready = !va_ff || ready_b;

   assign va_in = (in_valid && in_ready) ? 1'b1 : (ready_b ? 1'b0 : va_ff);
   assign vb_in = ready_b ? va_ff : vb_ff;
   assign vc_in = ready_c ? vb_ff : vc_ff;
   assign vd_in = ready_d ? vc_ff : vd_ff;

   assign b_prod = a_ff.offset[OFFSET_W-1:2] * RECIP7;
   assign b_q_in = b_prod[RECIP_SHIFT+8:RECIP_SHIFT];

   assign c_prod     = b_q_ff * RECIP21;
   assign c_qq_in    = c_prod[RECIP_SHIFT+4:RECIP_SHIFT];
   assign c_fin_full = b_ff.offset - OFFSET_W'(b_q_ff * FINAL_COUNT);
   assign c_fin_in   = c_fin_full[4:0];

   assign d_vowel_full = c_q_ff - 9'(c_qq_ff * VOWEL_COUNT);
   assign d_vowel      = d_vowel_full[4:0];
   assign d_last       = c_ff.syllable_seen ? (HANGUL_FIRST + {2'd0, c_ff.offset}) : 16'd0;
   assign d_pos        = c_ff.syllable_seen
                         && (d_vowel == 5'd0 || d_vowel == 5'd2 || d_vowel == 5'd8);
   assign d_fvl        = c_ff.syllable_seen && (c_fin_ff == 5'd0 || c_fin_ff == 5'd8);
   assign d_in = {2'b00, d_fvl, d_pos, c_fin_ff, d_vowel, d_last,
                  c_ff.syllable_seen, c_ff.decoded_ok};

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else begin
         va_ff <= va_in;
         vb_ff <= vb_in;
         vc_ff <= vc_in;
         vd_ff <= vd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) a_ff <= in_sum;
      if (ready_b) begin
         b_ff   <= a_ff;
         b_q_ff <= b_q_in;
      end
      if (ready_c) begin
         c_ff     <= b_ff;
         c_q_ff   <= b_q_ff;
         c_qq_ff  <= c_qq_in;
         c_fin_ff <= c_fin_in;
      end
      if (ready_d) d_ff <= d_in;
   end

   assign rsp_tvalid = vd_ff;
   assign rsp_tdata  = d_ff;

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      vd_ff |-> (d_ff[22:18] < 5'(VOWEL_COUNT) && d_ff[27:23] < 5'(FINAL_COUNT)))
      else $error("syllable index out of range");

   a_seen_implies_ok: assert property (@(posedge clock) disable iff (reset)
      vd_ff |-> (!d_ff[1] || d_ff[0]) && (d_ff[1] || (d_ff[29:2] == '0)))
      else $error("result fields set without a syllable");

   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      (vc_ff && ready_d) |=> vd_ff)
      else $error("result lost between stages");

endmodule
`default_nettype wire

[sv/utf8_last_hangul_classifier.sv]
// Top level of the UTF-8 last-Hangul-syllable classifier.
// Throughput: one byte transaction per cycle while req_tready is high; the decoder state is registered.
// The result of a zero byte is offered on rsp after its transaction has passed
//   through a four-register pipe (summary, /28, /21 and final index, output register).
// Backpressure on rsp only stalls req once all four result registers are full.
// Reset (synchronous, active high) clears the decoder state and all pipeline valids.
`default_nettype none
module utf8_last_hangul_classifier
   import ulhc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   // byte stream
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [7:0]       req_tdata,   // [7:0] in_byte
   // one result per string
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata    // [0] decoded_ok, [1] syllable_seen,
                                              // [17:2] last_syllable, [22:18] vowel_index,
                                              // [27:23] coda_index, [28] positive_vowel,
                                              // [29] final_vowel_or_l, [31:30] zero
);

   logic         req_accept;
   logic         end_of_string;
   ulhc_sum_type summary;

   // a byte transaction completes; a zero byte also pushes a result
   assign req_accept    = req_tvalid && req_tready;
   assign end_of_string = req_accept && (req_tdata == 8'd0);

   // decoder state captures the string; summary reflects the state before this byte
   ulhc_decoder u_decoder (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_accept),
      .in_byte (req_tdata),
      .summary (summary)
   );

   // result pipeline doubles as the skid buffer between req and rsp
   ulhc_split u_split (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (end_of_string),
      .in_ready   (req_tready),
      .in_sum     (summary),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire
